### src/cdu_pkg.sv
`default_nettype none

package cdu_pkg;

  localparam int DATE_W = 27;
  localparam int YEAR_W = 14;
  localparam int DOY_W  = 9;
  localparam int DIFF_W = 23;
  localparam int DC_W   = 22;
  localparam int TDATA_W = 80;

  localparam logic [1:0] FN_TO_DOY   = 2'd0;
  localparam logic [1:0] FN_FROM_DOY = 2'd1;
  localparam logic [1:0] FN_NEXT     = 2'd2;
  localparam logic [1:0] FN_DIFF     = 2'd3;

  localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

  // Decoded date, as it leaves the split pipeline.
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [6:0]        month;
    logic [6:0]        day;
    logic              leap;
    logic [12:0]       corr;   // ceil(y/4) - ceil(y/100) + ceil(y/400)
  } dec_t;

  // Load enables of the three split stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Days before the first of month idx + 1 (idx 12 gives the year length).
  function automatic logic [DOY_W-1:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [DOY_W-1:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      4'd12:   base = 9'd365;
      default: base = 9'd0;
    endcase
    return base + 9'(leap && idx >= 4'd2 && idx <= 4'd12);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### src/cdu_date_dec.sv
`default_nettype none

module cdu_date_dec (
  input  wire logic                      clk,
  input  wire cdu_pkg::stage_en_t        en,
  input  wire logic [cdu_pkg::DATE_W-1:0] date_in,
  input  wire logic [cdu_pkg::YEAR_W-1:0] year_in,
  input  wire logic                      use_year,
  output cdu_pkg::dec_t                  dec_o
);
  import cdu_pkg::*;

  // Reciprocals: x / 625 for x < 2**23 is (x * M) >> 33, x / 25 for
  // x < 2**12 is (x * 5243) >> 17.
  localparam logic [23:0] DIV625_MUL = 24'd13743896;
  localparam logic [12:0] DIV25_MUL  = 13'd5243;

  logic [46:0]        quo_prod;
  logic [YEAR_W-1:0]  year1_nxt, year1_r;
  logic [DATE_W-1:0]  date1_r;

  logic [DATE_W-1:0]  rem_full;
  logic [24:0]        cent_prod;
  logic [YEAR_W-1:0]  year2_r;
  logic [13:0]        rem2_r;
  logic [7:0]         cent2_r;

  logic [24:0]        mon_prod;
  logic [6:0]         month;
  logic [6:0]         day;
  logic [6:0]         yr_rem;
  logic               yr_rem_nz;
  logic [12:0]        ceil4, ceil100, ceil400;
  dec_t               dec3_nxt, dec3_r;

  // Stage 1: year = date / 10000 = (date >> 4) / 625.
  assign quo_prod  = 47'(date_in[26:4]) * 47'(DIV625_MUL);
  assign year1_nxt = use_year ? year_in : quo_prod[46:33];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      year1_r <= year1_nxt;
      date1_r <= date_in;
    end
  end

  // Stage 2: month-day remainder and century count of the year.
  assign rem_full  = date1_r - 27'(year1_r) * 27'd10000;
  assign cent_prod = 25'(year1_r[13:2]) * 25'(DIV25_MUL);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      year2_r <= year1_r;
      rem2_r  <= rem_full[13:0];
      cent2_r <= cent_prod[24:17];
    end
  end

  // Stage 3: month and day digits, leap flag and the leap-day correction.
  assign mon_prod  = 25'(rem2_r[13:2]) * 25'(DIV25_MUL);
  assign month     = mon_prod[23:17];
  assign day       = 7'(rem2_r - 14'(month) * 14'd100);
  assign yr_rem    = 7'(year2_r - 14'(cent2_r) * 14'd100);
  assign yr_rem_nz = (yr_rem != 7'd0);
  assign ceil4     = 13'(year2_r[13:2]) + 13'(year2_r[1:0] != 2'd0);
  assign ceil100   = 13'(cent2_r) + 13'(yr_rem_nz);
  assign ceil400   = 13'(cent2_r[7:2]) + 13'((cent2_r[1:0] != 2'd0) || yr_rem_nz);

  always_comb begin
    dec3_nxt.year  = year2_r;
    dec3_nxt.month = month;
    dec3_nxt.day   = day;
    dec3_nxt.leap  = (year2_r[1:0] == 2'd0) && (yr_rem_nz || cent2_r[1:0] == 2'd0);
    dec3_nxt.corr  = ceil4 - ceil100 + ceil400;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      dec3_r <= dec3_nxt;
    end
  end

  assign dec_o = dec3_r;

endmodule

`default_nettype wire

### src/calendar_date_unit.sv
`default_nettype none

// Channel  | Ports                          | Contents
// ---------+--------------------------------+-------------------------------------------
// request  | in_tvalid/in_tready/in_tdata   | tuser: func; tdata: date_a, date_b,
//          | in_tuser                       | year_in, day_of_year
// result   | out_tvalid/out_tready/out_tdata| tdata: date_out, year_out, day_of_year_out,
//          | out_tuser                      | day_diff; tuser: error
//
// One transaction is accepted per cycle unless out_tready low stalls a full pipeline; its
// result appears once it has passed the input register (loaded at the accepting edge), the
// three date split stages, the evaluation stage and the output register.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up and input is taken while a result waits.
// Reset clears only the valid bits.
module calendar_date_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output      logic                       in_tready,
  // [26:0] date_a, [53:27] date_b, [67:54] year_in, [76:68] day_of_year
  input  wire logic [cdu_pkg::TDATA_W-1:0] in_tdata,
  // [1:0] func
  input  wire logic [1:0]                 in_tuser,
  output      logic                       out_tvalid,
  input  wire logic                       out_tready,
  // [26:0] date_out, [40:27] year_out, [49:41] day_of_year_out, [72:50] day_diff
  output      logic [cdu_pkg::TDATA_W-1:0] out_tdata,
  // [0] error
  output      logic                       out_tuser
);
  import cdu_pkg::*;

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld_r, vld_nxt, stg_rdy;

  // Input register.
  logic [1:0]        func0_r, func1_r, func2_r, func3_r, func4_r;
  logic [DATE_W-1:0] da0_r, db0_r;
  logic [YEAR_W-1:0] yin0_r;
  logic [DOY_W-1:0]  din0_r, din1_r, din2_r, din3_r;

  stage_en_t dec_en;
  dec_t      dec_a, dec_b;

  // Evaluation stage.
  logic              ok_a, ok_b;
  logic [DOY_W-1:0]  doy_a, doy_b, year_len;
  logic [DC_W-1:0]   dc_a, dc_b;
  logic [3:0]        mon_cnt;
  logic [DOY_W-1:0]  mon_day;
  logic [4:0]        mlen_a;
  logic              err4_nxt, err4_r;
  logic [YEAR_W-1:0] y4_nxt, y4_r;
  logic [3:0]        mon4_nxt, mon4_r;
  logic [4:0]        day4_nxt, day4_r;
  logic [DOY_W-1:0]  doy4_nxt, doy4_r;
  logic [DC_W-1:0]   dca4_r, dcb4_r;

  // Output register.
  logic              use_date;
  logic [DATE_W-1:0] date_out_nxt, date_out_r;
  logic [YEAR_W-1:0] year_out_r;
  logic [DOY_W-1:0]  doy_out_r;
  logic [DIFF_W-1:0] diff_nxt, diff_r;
  logic              err_r;

  function automatic logic date_ok(input dec_t d);
    logic mon_ok;
    mon_ok = (d.month >= 7'd1) && (d.month <= 7'd12);
    return (d.year <= MAX_YEAR) && mon_ok && (d.day >= 7'd1) &&
           (d.day <= 7'(month_len(d.leap, d.month[3:0])));
  endfunction

  // Pipeline flow control.
  always_comb begin
    stg_rdy[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_rdy[k] = !vld_r[k] || stg_rdy[k+1];
    end
    vld_nxt[0] = stg_rdy[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = stg_rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = stg_rdy[0];
  assign out_tvalid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (stg_rdy[0]) begin
      func0_r <= in_tuser;
      da0_r   <= in_tdata[26:0];
      db0_r   <= in_tdata[53:27];
      yin0_r  <= in_tdata[67:54];
      din0_r  <= in_tdata[76:68];
    end
  end

  // Split stages: date A also carries year_in for the day-of-year conversion.
  always_comb begin
    dec_en.s1 = stg_rdy[1];
    dec_en.s2 = stg_rdy[2];
    dec_en.s3 = stg_rdy[3];
  end

  cdu_date_dec u_dec_a (
    .clk      (clk),
    .en       (dec_en),
    .date_in  (da0_r),
    .year_in  (yin0_r),
    .use_year (func0_r == FN_FROM_DOY),
    .dec_o    (dec_a)
  );

  cdu_date_dec u_dec_b (
    .clk      (clk),
    .en       (dec_en),
    .date_in  (db0_r),
    .year_in  ('0),
    .use_year (1'b0),
    .dec_o    (dec_b)
  );

  always_ff @(posedge clk) begin
    if (stg_rdy[1]) begin
      func1_r <= func0_r;
      din1_r  <= din0_r;
    end
    if (stg_rdy[2]) begin
      func2_r <= func1_r;
      din2_r  <= din1_r;
    end
    if (stg_rdy[3]) begin
      func3_r <= func2_r;
      din3_r  <= din2_r;
    end
  end

  // Evaluation stage.
  assign ok_a     = date_ok(dec_a);
  assign ok_b     = date_ok(dec_b);
  assign doy_a    = cum_days(dec_a.leap, dec_a.month[3:0] - 4'd1) + 9'(dec_a.day);
  assign doy_b    = cum_days(dec_b.leap, dec_b.month[3:0] - 4'd1) + 9'(dec_b.day);
  assign dc_a     = 22'(dec_a.year) * 22'd365 + 22'(dec_a.corr) + 22'(doy_a);
  assign dc_b     = 22'(dec_b.year) * 22'd365 + 22'(dec_b.corr) + 22'(doy_b);
  assign year_len = cum_days(dec_a.leap, 4'd12);
  assign mlen_a   = month_len(dec_a.leap, dec_a.month[3:0]);

  // Month search for the day-of-year conversion; day 0 stays in month 0.
  always_comb begin
    mon_cnt = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (din3_r > cum_days(dec_a.leap, 4'(i))) begin
        mon_cnt = 4'(i + 1);
      end
    end
    if (mon_cnt == 4'd0) begin
      mon_day = din3_r;
    end else begin
      mon_day = din3_r - cum_days(dec_a.leap, mon_cnt - 4'd1);
    end
  end

  always_comb begin
    err4_nxt = 1'b0;
    y4_nxt   = '0;
    mon4_nxt = '0;
    day4_nxt = '0;
    doy4_nxt = '0;
    case (func3_r)
      FN_TO_DOY: begin
        if (!ok_a) begin
          err4_nxt = 1'b1;
        end else begin
          y4_nxt   = dec_a.year;
          doy4_nxt = doy_a;
        end
      end
      FN_FROM_DOY: begin
        if (dec_a.year > MAX_YEAR) begin
          err4_nxt = 1'b1;
        end else if (din3_r > year_len) begin
          y4_nxt   = dec_a.year;
          mon4_nxt = 4'd12;
          day4_nxt = 5'd31;
        end else begin
          y4_nxt   = dec_a.year;
          mon4_nxt = mon_cnt;
          day4_nxt = mon_day[4:0];
        end
      end
      FN_NEXT: begin
        if (!ok_a) begin
          err4_nxt = 1'b1;
        end else if (dec_a.day[4:0] < mlen_a) begin
          y4_nxt   = dec_a.year;
          mon4_nxt = dec_a.month[3:0];
          day4_nxt = dec_a.day[4:0] + 5'd1;
        end else if (dec_a.month[3:0] < 4'd12) begin
          y4_nxt   = dec_a.year;
          mon4_nxt = dec_a.month[3:0] + 4'd1;
          day4_nxt = 5'd1;
        end else if (dec_a.year >= MAX_YEAR) begin
          err4_nxt = 1'b1;
        end else begin
          y4_nxt   = dec_a.year + 14'd1;
          mon4_nxt = 4'd1;
          day4_nxt = 5'd1;
        end
      end
      FN_DIFF: begin
        err4_nxt = !ok_a || !ok_b;
      end
      default: begin
        err4_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[4]) begin
      func4_r <= func3_r;
      err4_r  <= err4_nxt;
      y4_r    <= y4_nxt;
      mon4_r  <= mon4_nxt;
      day4_r  <= day4_nxt;
      doy4_r  <= doy4_nxt;
      dca4_r  <= dc_a;
      dcb4_r  <= dc_b;
    end
  end

  // Output stage: compose the decimal date and the day difference.
  assign use_date     = (func4_r == FN_FROM_DOY) || (func4_r == FN_NEXT);
  assign date_out_nxt = 27'(y4_r) * 27'd10000 + 27'(mon4_r) * 27'd100 + 27'(day4_r);
  assign diff_nxt     = 23'(dcb4_r) - 23'(dca4_r);

  always_ff @(posedge clk) begin
    if (stg_rdy[5]) begin
      err_r      <= err4_r;
      date_out_r <= (use_date && !err4_r) ? date_out_nxt : '0;
      year_out_r <= (func4_r == FN_TO_DOY && !err4_r) ? y4_r : '0;
      doy_out_r  <= (func4_r == FN_TO_DOY && !err4_r) ? doy4_r : '0;
      diff_r     <= (func4_r == FN_DIFF && !err4_r) ? diff_nxt : '0;
    end
  end

  assign out_tdata = {7'd0, diff_r, doy_out_r, year_out_r, date_out_r};
  assign out_tuser = err_r;

endmodule

`default_nettype wire
